// ===== hdl/adceu_pkg.sv =====
// adceu_pkg: request/result types, codes and fixed-point constants for the
// sensor ADC to engineering units converter. No dependencies.
`default_nettype none

package adceu_pkg;

    localparam int ADC_BITS = 14;

    localparam int SAMPLE_W = 14;
    localparam int VALUE_W  = 18;
    localparam int THR_W    = 12;
    localparam int MV_W     = 20;
    localparam int DISC_W   = 36;
    localparam int ROOT_W   = 26;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int REM_W    = ROOT_W + 1;
    localparam int X_W      = 32;
    localparam int RECIP_W  = 21;
    localparam int Q_W      = 21;
    localparam int DIV_W    = 16;
    localparam int BIAS_W   = Q_W + 3;

    // op / kind codes
    localparam logic [1:0] OP_TEMP = 2'd0;
    localparam logic [1:0] OP_CO   = 2'd1;
    localparam logic [1:0] OP_LPG  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // register index (paddr[2])
    localparam logic REG_CO  = 1'b0;
    localparam logic REG_LPG = 1'b1;

    localparam logic [THR_W-1:0] THR_RESET = 12'd700;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << ADC_BITS) - 64'd1);

    // 3300 mV full scale, 8 fraction bits
    localparam logic [MV_W-1:0] MV_SCALE = 20'd844800;

    // discriminant of the temperature curve, scaled
    localparam logic [DISC_W-1:0] DISC_BASE  = 36'd36663671808;
    localparam logic [13:0]       DISC_SLOPE = 14'd13880;

    // temperature: x = 45*root - offset, already biased non-negative
    localparam logic [X_W-1:0] TEMP_GAIN   = 32'd45;
    localparam logic [X_W-1:0] TEMP_OFFSET = 32'd1815865152;

    // gas: x = gain*mv + bias, offset and rounding half folded in
    localparam logic [X_W-1:0] CO_GAIN   = 32'd37;
    localparam logic [X_W-1:0] CO_BIAS   = 32'd2190;
    localparam logic [X_W-1:0] LPG_GAIN  = 32'd3607;
    localparam logic [X_W-1:0] LPG_BIAS  = 32'd20160;

    typedef struct packed {
        logic [1:0]          op;
        logic [SAMPLE_W-1:0] sample;
    } conv_req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                kind;
    } conv_res_t;

    // floor(2^32 / divisor)
    function automatic logic [RECIP_W-1:0] recip_of(input logic [1:0] op);
        logic [RECIP_W-1:0] m;
        unique case (op)
            OP_TEMP: m = 21'd96698;
            OP_CO:   m = 21'd1717986;
            OP_LPG:  m = 21'd268435;
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [DIV_W-1:0] divisor_of(input logic [1:0] op);
        logic [DIV_W-1:0] d;
        unique case (op)
            OP_TEMP: d = 16'd44416;
            OP_CO:   d = 16'd2500;
            OP_LPG:  d = 16'd16000;
            default: d = 16'd1;
        endcase
        return d;
    endfunction

    // bias removed after the divide; temperature also adds 1376
    function automatic logic signed [BIAS_W-1:0] bias_of(input logic [1:0] op);
        logic signed [BIAS_W-1:0] b;
        unique case (op)
            OP_TEMP: b = 24'sd2924;
            OP_CO:   b = 24'sd9053;
            OP_LPG:  b = 24'sd91715;
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sensor_adc_to_engineering_units.sv =====
// sensor_adc_to_engineering_units: top level, ADC count to degF / ppm in sixteenths.
// Depends on adceu_pkg.
//
// Request channel conv (op, sample) with conv_valid / conv_stall; result channel
// result (value, kind) with result_valid / result_stall. Thresholds sit on the
// APB port: 0x0 CO, 0x4 LPG (12 bit). The user must write them only while idle;
// the block itself does not enforce this.
// Throughput: one request per cycle while conv_stall is low; the square root is
// 26 register stages of one root bit each, then a reciprocal divide over three stages.
// Reset clears all valid bits and sets both thresholds to 700 mV.
// A stalled result holds in the output register; empty stages further up keep
// filling, and conv_stall rises only once every stage holds a request.
`default_nettype none

module sensor_adc_to_engineering_units (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  conv_valid,
    output logic                  conv_stall,
    input  adceu_pkg::conv_req_t  conv,
    output logic                  result_valid,
    input  logic                  result_stall,
    output adceu_pkg::conv_res_t  result
);
    import adceu_pkg::*;

    localparam int ST_MV  = 0;
    localparam int ST_RAD = 1;
    localparam int ST_SQ0 = 2;
    localparam int ST_X   = ST_SQ0 + ROOT_W;
    localparam int ST_Q0  = ST_X + 1;
    localparam int ST_QD  = ST_X + 2;
    localparam int ST_OUT = ST_X + 3;
    localparam int NST    = ST_OUT + 1;

    localparam logic signed [VALUE_W-1:0] TEMP_MIN = -18'sd3000;
    localparam logic signed [VALUE_W-1:0] TEMP_MAX = 18'sd6000;

    typedef struct packed {
        logic [1:0]      op;
        logic [MV_W-1:0] mv;
    } mv_stage_t;

    typedef struct packed {
        logic [1:0]       op;
        logic             below;
        logic [X_W-1:0]   gx;
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } sq_stage_t;

    typedef struct packed {
        logic [1:0]     op;
        logic           below;
        logic [X_W-1:0] x;
        logic [Q_W-1:0] q0;
        logic [X_W-1:0] qd;
    } div_stage_t;

    logic [NST-1:0]   v_reg;
    logic [NST-1:0]   v_next;
    logic [NST-1:0]   adv;
    logic [THR_W-1:0] co_thr_reg;
    logic [THR_W-1:0] lpg_thr_reg;
    logic             cfg_wr;

    mv_stage_t  mv_reg, mv_next;
    sq_stage_t  rad_reg, rad_next;
    sq_stage_t  sq_reg  [ROOT_W];
    sq_stage_t  sq_next [ROOT_W];
    sq_stage_t  sq_prev [ROOT_W];
    logic [REM_W+1:0] sq_t     [ROOT_W];
    logic [REM_W+2:0] sq_trial [ROOT_W];
    div_stage_t x_reg, x_next;
    div_stage_t q0_reg, q0_next;
    div_stage_t qd_reg, qd_next;
    conv_res_t  res_reg, res_next;

    logic [SAMPLE_W-1:0]        sample_m;
    logic [SAMPLE_W+MV_W-1:0]   mv_prod;
    logic [MV_W+13:0]           disc_sub;
    logic [X_W+RECIP_W-1:0]     recip_prod;
    logic [Q_W+DIV_W-1:0]       qd_prod;
    logic [X_W-1:0]             rem_fin;
    logic                       corr;
    logic [Q_W:0]               q_fin;
    logic signed [BIAS_W-1:0]   val_wide;
    logic                       zero_res;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            co_thr_reg  <= THR_RESET;
            lpg_thr_reg <= THR_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_CO:  co_thr_reg  <= pwdata[THR_W-1:0];
                REG_LPG: lpg_thr_reg <= pwdata[THR_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_CO:  prdata = {{(32-THR_W){1'b0}}, co_thr_reg};
            REG_LPG: prdata = {{(32-THR_W){1'b0}}, lpg_thr_reg};
        endcase
    end

    // elastic pipeline: a stage moves when the output drains or it or any later one is empty
    always_comb
    begin
        for (int i = 0; i < NST; i++)
        begin
            adv[i] = !result_stall || ((~v_reg >> i) != '0);
        end
        v_next[0] = adv[0] ? conv_valid : v_reg[0];
        for (int i = 1; i < NST; i++)
        begin
            v_next[i] = adv[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    assign conv_stall = !adv[ST_MV];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // stage: millivolts, 8 fraction bits
    always_comb
    begin
        sample_m   = conv.sample & SAMPLE_MASK;
        mv_prod    = (SAMPLE_W+MV_W)'(sample_m) * (SAMPLE_W+MV_W)'(MV_SCALE);
        mv_next.op = conv.op;
        mv_next.mv = MV_W'(mv_prod >> ADC_BITS);
    end

    // stage: radicand for temperature, biased numerator and threshold for gas
    always_comb
    begin
        disc_sub       = (MV_W+14)'(mv_reg.mv) * (MV_W+14)'(DISC_SLOPE);
        rad_next.op    = mv_reg.op;
        rad_next.rad   = {DISC_BASE - DISC_W'(disc_sub), {(RAD_W-DISC_W){1'b0}}};
        rad_next.rem   = '0;
        rad_next.root  = '0;
        unique case (mv_reg.op)
            OP_CO:
            begin
                rad_next.gx    = X_W'(mv_reg.mv) * CO_GAIN + CO_BIAS;
                rad_next.below = mv_reg.mv < {co_thr_reg, 8'b0};
            end
            OP_LPG:
            begin
                rad_next.gx    = X_W'(mv_reg.mv) * LPG_GAIN + LPG_BIAS;
                rad_next.below = mv_reg.mv < {lpg_thr_reg, 8'b0};
            end
            default:
            begin
                rad_next.gx    = '0;
                rad_next.below = 1'b0;
            end
        endcase
    end

    // square root, one result bit per stage
    always_comb
    begin
        for (int k = 0; k < ROOT_W; k++)
        begin
            if (k == 0)
            begin
                sq_prev[k] = rad_reg;
            end
            else
            begin
                sq_prev[k] = sq_reg[k-1];
            end
            sq_t[k]     = {sq_prev[k].rem, sq_prev[k].rad[RAD_W-1 -: 2]};
            sq_trial[k] = {1'b0, sq_t[k]} - (REM_W+3)'({sq_prev[k].root, 2'b01});
            sq_next[k]     = sq_prev[k];
            sq_next[k].rad = sq_prev[k].rad << 2;
            if (!sq_trial[k][REM_W+2])
            begin
                sq_next[k].rem  = sq_trial[k][REM_W-1:0];
                sq_next[k].root = {sq_prev[k].root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_next[k].rem  = sq_t[k][REM_W-1:0];
                sq_next[k].root = {sq_prev[k].root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // stage: dividend, non-negative for every request
    always_comb
    begin
        x_next.op    = sq_reg[ROOT_W-1].op;
        x_next.below = sq_reg[ROOT_W-1].below;
        x_next.q0    = '0;
        x_next.qd    = '0;
        if (sq_reg[ROOT_W-1].op == OP_TEMP)
        begin
            x_next.x = X_W'(X_W'(sq_reg[ROOT_W-1].root) * TEMP_GAIN) - TEMP_OFFSET;
        end
        else
        begin
            x_next.x = sq_reg[ROOT_W-1].gx;
        end
    end

    // stage: quotient estimate by reciprocal, low by at most one
    always_comb
    begin
        recip_prod = (X_W+RECIP_W)'(x_reg.x) * (X_W+RECIP_W)'(recip_of(x_reg.op));
        q0_next    = x_reg;
        q0_next.q0 = recip_prod[X_W+RECIP_W-1 -: Q_W];
    end

    // stage: back-multiply
    always_comb
    begin
        qd_prod    = (Q_W+DIV_W)'(q0_reg.q0) * (Q_W+DIV_W)'(divisor_of(q0_reg.op));
        qd_next    = q0_reg;
        qd_next.qd = X_W'(qd_prod);
    end

    // stage: correction, unbias, result register
    always_comb
    begin
        rem_fin  = qd_reg.x - qd_reg.qd;
        corr     = rem_fin >= X_W'(divisor_of(qd_reg.op));
        q_fin    = (Q_W+1)'(qd_reg.q0) + (Q_W+1)'(corr);
        val_wide = $signed({2'b00, q_fin}) - bias_of(qd_reg.op);
        zero_res = (qd_reg.op == OP_NONE) || ((qd_reg.op != OP_TEMP) && qd_reg.below);
        res_next.kind  = qd_reg.op;
        res_next.value = zero_res ? '0 : VALUE_W'(val_wide);
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_MV])
        begin
            mv_reg <= mv_next;
        end
        if (adv[ST_RAD])
        begin
            rad_reg <= rad_next;
        end
        for (int k = 0; k < ROOT_W; k++)
        begin
            if (adv[ST_SQ0+k])
            begin
                sq_reg[k] <= sq_next[k];
            end
        end
        if (adv[ST_X])
        begin
            x_reg <= x_next;
        end
        if (adv[ST_Q0])
        begin
            q0_reg <= q0_next;
        end
        if (adv[ST_QD])
        begin
            qd_reg <= qd_next;
        end
        if (adv[ST_OUT])
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = v_reg[ST_OUT];
    assign result       = res_reg;

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        conv_stall |-> ((&v_reg) && result_stall))
        else $error("request stalled with a free stage");

    a_root_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_X-1] |-> (sq_reg[ROOT_W-1].rem <= {sq_reg[ROOT_W-1].root, 1'b0}))
        else $error("square root remainder out of bound");

    a_unused_op_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.kind == OP_NONE)) |-> (result.value == '0))
        else $error("unused op gave a non-zero value");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.kind == OP_TEMP))
            |-> (($signed(result.value) >= TEMP_MIN) && ($signed(result.value) <= TEMP_MAX)))
        else $error("temperature result out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for sensor_adc_to_engineering_units.
// Drives requests and APB threshold writes, predicts each result in fixed point.
// Depends on adceu_pkg and the top-level RTL.

module testbench;

    import adceu_pkg::*;

    localparam int     QUIET_LIMIT  = 3000;
    localparam int     TAIL_CYCLES  = 40;
    localparam longint ADC_MASK     = (longint'(1) << ADC_BITS) - 1;
    localparam longint MV_PER_FS_Q8 = 3300 * 256;
    localparam longint DISC_AT_ZERO = 256 * (longint'(118548544) + longint'(1388) * 17773);
    localparam longint DISC_PER_MV  = 13880;
    localparam longint ROOT_AT_ZERO = 44597248;
    localparam longint TEMP_NUM     = 45;
    localparam longint TEMP_DEN     = 44416;
    localparam longint TEMP_ZERO_F  = 1376;
    localparam longint CO_SLOPE     = 37;
    localparam longint CO_OFFSET    = 22631560;
    localparam longint CO_DEN       = 2500;
    localparam longint LPG_SLOPE    = 3607;
    localparam longint LPG_OFFSET   = 1467427840;
    localparam longint LPG_DEN      = 16000;
    localparam logic [2:0] ADDR_CO  = {REG_CO, 2'b00};
    localparam logic [2:0] ADDR_LPG = {REG_LPG, 2'b00};

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        conv_valid   = 1'b0;
    logic        conv_stall;
    conv_req_t   conv         = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    conv_res_t   result;

    logic [THR_W-1:0] co_thr_mv  = THR_RESET;
    logic [THR_W-1:0] lpg_thr_mv = THR_RESET;
    conv_res_t        readings_due[$];
    int               mismatches  = 0;
    int               quiet_cycles = 0;
    bit               send_idle   = 1'b1;
    bit               stall_en    = 1'b1;

    sensor_adc_to_engineering_units u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .conv_valid   (conv_valid),
        .conv_stall   (conv_stall),
        .conv         (conv),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // nearest, halves toward plus infinity
    function automatic longint round_half_up(longint num, longint den);
        longint n2;
        longint d2;
        longint q;
        n2 = 2 * num + den;
        d2 = 2 * den;
        q  = n2 / d2;
        if ((n2 % d2) != 0 && n2 < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic conv_res_t predict_reading(logic [1:0] op, logic [SAMPLE_W-1:0] sample);
        conv_res_t       res;
        longint          mv;
        longint          val;
        longint unsigned rad;
        longint unsigned bitv;
        longint unsigned root;
        mv  = ((longint'(sample) & ADC_MASK) * MV_PER_FS_Q8) >>> ADC_BITS;
        val = 0;
        case (op)
            OP_TEMP:
            begin
                rad  = longint'(DISC_AT_ZERO - DISC_PER_MV * mv) * 65536;
                root = 0;
                bitv = 64'd1 << 62;
                while (bitv > rad)
                    bitv = bitv >> 2;
                while (bitv != 0)
                begin
                    if (rad >= root + bitv)
                    begin
                        rad  = rad - (root + bitv);
                        root = (root >> 1) + bitv;
                    end
                    else
                        root = root >> 1;
                    bitv = bitv >> 2;
                end
                val = round_half_up((longint'(root) - ROOT_AT_ZERO) * TEMP_NUM, TEMP_DEN)
                      + TEMP_ZERO_F;
            end
            OP_CO:
                if (mv >= (longint'(co_thr_mv) << 8))
                    val = round_half_up(CO_SLOPE * mv - CO_OFFSET, CO_DEN);
            OP_LPG:
                if (mv >= (longint'(lpg_thr_mv) << 8))
                    val = round_half_up(LPG_SLOPE * mv - LPG_OFFSET, LPG_DEN);
            default:
                val = 0;
        endcase
        res.value = val[VALUE_W-1:0];
        res.kind  = op;
        return res;
    endfunction

    // first count at or above the threshold, jittered by up to two
    function automatic logic [SAMPLE_W-1:0] near_threshold(logic [THR_W-1:0] thr);
        longint s;
        int     jitter;
        jitter = $urandom_range(0, 4);
        s = ((longint'(thr) << (8 + ADC_BITS)) + MV_PER_FS_Q8 - 1) / MV_PER_FS_Q8 + jitter - 2;
        if (s < 0)
            s = 0;
        if (s > ADC_MASK)
            s = ADC_MASK;
        return s[SAMPLE_W-1:0];
    endfunction

    function automatic conv_req_t random_request();
        conv_req_t req;
        req.op = ($urandom_range(0, 15) == 0) ? OP_NONE : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 7))
            0:       req.sample = near_threshold(req.op == OP_LPG ? lpg_thr_mv : co_thr_mv);
            1:       req.sample = $urandom_range(0, 1) ? '1 : '0;
            default: req.sample = SAMPLE_W'($urandom());
        endcase
        return req;
    endfunction

    task automatic send_request(logic [1:0] op, logic [SAMPLE_W-1:0] sample);
        conv_valid <= 1'b1;
        conv       <= '{op: op, sample: sample};
        do
            @(posedge clk);
        while (conv_stall);
        readings_due.push_back(predict_reading(op, sample));
        if (send_idle && $urandom_range(0, 3) == 0)
        begin
            conv_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        conv_valid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [THR_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {{(32-THR_W){1'b0}}, val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_CO)
            co_thr_mv = val;
        else
            lpg_thr_mv = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(logic [2:0] addr, logic [THR_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {{(32-THR_W){1'b0}}, want})
        begin
            $error("prdata: expected %0d, got %0d", want, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_thresholds(logic [THR_W-1:0] co, logic [THR_W-1:0] lpg);
        wait_for_results();
        apb_write(ADDR_CO, co);
        apb_write(ADDR_LPG, lpg);
        apb_read(ADDR_CO, co);
        apb_read(ADDR_LPG, lpg);
    endtask

    task automatic test_register_reset();
        apb_read(ADDR_CO, THR_RESET);
        apb_read(ADDR_LPG, THR_RESET);
    endtask

    // 3475 sits just below 700 mV, 3476 just above
    task automatic test_directed_corners();
        send_request(OP_TEMP, 14'd0);
        send_request(OP_TEMP, 14'h3FFF);
        send_request(OP_TEMP, 14'h2AAA);
        send_request(OP_TEMP, 14'h1555);
        send_request(OP_TEMP, 14'd8192);
        send_request(OP_CO, 14'd0);
        send_request(OP_CO, 14'd3475);
        send_request(OP_CO, 14'd3476);
        send_request(OP_CO, 14'h3FFF);
        send_request(OP_LPG, 14'd0);
        send_request(OP_LPG, 14'd3475);
        send_request(OP_LPG, 14'd3476);
        send_request(OP_LPG, 14'h3FFF);
        send_request(OP_NONE, 14'h3FFF);
        send_request(OP_NONE, 14'h2AAA);
    endtask

    task automatic test_threshold_edges();
        logic [THR_W-1:0] co_set[5];
        logic [THR_W-1:0] lpg_set[5];
        conv_req_t        req;
        co_set  = '{12'd0, 12'hFFF, 12'd3300, 12'd1, 12'd0};
        lpg_set = '{12'd0, 12'hFFF, 12'd1, 12'd3300, 12'd0};
        co_set[4]  = THR_W'($urandom_range(0, 3300));
        lpg_set[4] = THR_W'($urandom_range(0, 3300));
        for (int k = 0; k < 5; k++)
        begin
            set_thresholds(co_set[k], lpg_set[k]);
            for (int i = 0; i < 40; i++)
            begin
                req.op = i[0] ? OP_LPG : OP_CO;
                req.sample = (i % 4 < 2) ? near_threshold(i[0] ? lpg_thr_mv : co_thr_mv)
                                         : SAMPLE_W'($urandom());
                send_request(req.op, req.sample);
            end
        end
    endtask

    task automatic test_drain_pause();
        conv_req_t req;
        for (int i = 0; i < 60; i++)
        begin
            if (i == 30)
                wait_for_results();
            req = random_request();
            send_request(req.op, req.sample);
        end
    endtask

    task automatic test_random_stream();
        conv_req_t req;
        for (int i = 0; i < 1280; i++)
        begin
            if (i % 320 == 160)
                set_thresholds(THR_W'($urandom_range(0, 3300)), THR_W'($urandom_range(0, 3300)));
            if (i % 40 == 0)
            begin
                send_idle = ($urandom_range(0, 2) != 0);
                stall_en  = ($urandom_range(0, 2) != 0);
            end
            req = random_request();
            send_request(req.op, req.sample);
        end
    endtask

    task automatic test_back_to_back();
        conv_req_t req;
        send_idle = 1'b0;
        stall_en  = 1'b0;
        set_thresholds(THR_RESET, THR_RESET);
        for (int i = 0; i < 120; i++)
        begin
            req = random_request();
            send_request(req.op, req.sample);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_reset();
        test_directed_corners();
        test_threshold_edges();
        test_drain_pause();
        test_random_stream();
        test_back_to_back();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && readings_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        @(posedge clk);
        forever
        begin
            if (stall_en && $urandom_range(0, 2) == 0)
                result_stall <= 1'b1;
            else
                result_stall <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        conv_res_t due;
        if (rst_n && result_valid && !result_stall)
        begin
            if (readings_due.size() == 0)
            begin
                $error("result with no request pending: value %0d kind %0d",
                       result.value, result.kind);
                mismatches++;
            end
            else
            begin
                due = readings_due.pop_front();
                if (result.value !== due.value)
                begin
                    $error("value: expected %0d, got %0d", due.value, result.value);
                    mismatches++;
                end
                if (result.kind !== due.kind)
                begin
                    $error("kind: expected %0d, got %0d", due.kind, result.kind);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((conv_valid && !conv_stall) || (result_valid && !result_stall)
                || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule

// ===== filelist.f =====
hdl/adceu_pkg.sv
hdl/sensor_adc_to_engineering_units.sv
tb/testbench.sv
